// ===== design/credit_throttle_with_queue_macros.svh =====
// Assertion macros shared by the credit throttle checker.
`ifndef CREDIT_THROTTLE_WITH_QUEUE_MACROS_SVH
`define CREDIT_THROTTLE_WITH_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ctq_pkg.sv =====
// Shared types, constants and helpers of the credit throttle.
`default_nettype none

package ctq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_WIDTH   = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CREDIT_W    = 4;
  localparam int TICK_W      = 16;

  localparam logic [CREDIT_W-1:0] CREDIT_MAX_RST    = CREDIT_W'(4);
  localparam logic [TICK_W-1:0]   TICK_INTERVAL_RST = TICK_W'(1200);

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CREDIT_W-1:0]  credit_t;
  typedef logic [TICK_W-1:0]    tick_t;
  typedef logic [TAG_WIDTH-1:0] tag_t;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_TICK    = 1'b1
  } ctq_op_t;

  typedef enum logic {
    REG_CREDIT_MAX    = 1'b0,
    REG_TICK_INTERVAL = 1'b1
  } ctq_reg_t;

  typedef struct packed {
    tag_t       tag;
    logic [1:0] method;
  } ctq_entry_t;

  typedef struct packed {
    credit_t credit_max;
    tick_t   tick_interval;
  } ctq_cfg_t;

  typedef struct packed {
    logic       we;
    ptr_t       waddr;
    ctq_entry_t wdata;
    ptr_t       raddr;
  } ctq_qacc_t;

  typedef struct packed {
    logic       issue_valid;
    tag_t       issued_tag;
    logic [1:0] issued_method;
    logic       from_queue;
    logic       dropped;
    credit_t    credits_left;
    cnt_t       queue_level;
    logic       timer_running;
  } ctq_result_t;

  function automatic ptr_t next_slot(input ptr_t p);
    next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

endpackage

`default_nettype wire

// ===== design/ctq_ram.sv =====
// Single-port-write, registered-read RAM holding the waiting queue.
`default_nettype none

module ctq_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a collision; the controller forwards
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/ctq_ctrl.sv =====
// Credit, timer and queue-pointer control with the registered result.
`default_nettype none

module ctq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic                op,
  input  wire ctq_pkg::tag_t       tag,
  input  wire logic [1:0]          method,
  input  wire ctq_pkg::ctq_cfg_t   cfg,
  input  wire logic                cfg_load_credit,
  input  wire ctq_pkg::credit_t    cfg_credit_val,
  input  wire ctq_pkg::ctq_entry_t rd_data,
  output ctq_pkg::ctq_qacc_t       qacc,
  output ctq_pkg::ctq_result_t     result,
  output logic                     strobe
);
  import ctq_pkg::*;

  credit_t     credit_r, credit_nxt, item_credit;
  ptr_t        head_r, head_nxt;
  ptr_t        tail_r, tail_nxt;
  cnt_t        count_r, count_nxt;
  logic        timer_r, timer_nxt;
  tick_t       tick_r, tick_nxt;
  logic        fwd_r, fwd_nxt;
  ctq_entry_t  fwd_data_r;
  ctq_entry_t  head_ent;
  ctq_result_t res_r, res_nxt;
  logic        strobe_r;
  logic [TICK_W:0] tick_inc;

  assign head_ent = fwd_r ? fwd_data_r : rd_data;
  assign tick_inc = {1'b0, tick_r} + 1'b1;

  always_comb begin
    item_credit = credit_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    timer_nxt   = timer_r;
    tick_nxt    = tick_r;
    res_nxt     = '0;
    qacc.we     = 1'b0;
    qacc.waddr  = tail_r;
    qacc.wdata  = '{tag: tag, method: method};

    if (accept) begin
      if (ctq_op_t'(op) == OP_REQUEST) begin
        if (credit_r != '0) begin
          item_credit           = credit_r - 1'b1;
          res_nxt.issue_valid   = 1'b1;
          res_nxt.issued_tag    = tag;
          res_nxt.issued_method = method;
        end else if (count_r != CNT_W'(QUEUE_DEPTH)) begin
          qacc.we   = 1'b1;
          tail_nxt  = next_slot(tail_r);
          count_nxt = count_r + 1'b1;
        end else begin
          res_nxt.dropped = 1'b1;
        end
        if (!timer_r) begin
          timer_nxt = 1'b1;
          tick_nxt  = '0;
        end
      end else if (timer_r) begin
        if (tick_inc >= {1'b0, cfg.tick_interval}) begin
          tick_nxt = '0;
          if (count_r == '0) begin
            if (credit_r < cfg.credit_max) begin
              item_credit = credit_r + 1'b1;
            end
            if (item_credit >= cfg.credit_max) begin
              timer_nxt = 1'b0;
            end
          end else begin
            res_nxt.issue_valid   = 1'b1;
            res_nxt.from_queue    = 1'b1;
            res_nxt.issued_tag    = head_ent.tag;
            res_nxt.issued_method = head_ent.method;
            head_nxt              = next_slot(head_r);
            count_nxt             = count_r - 1'b1;
          end
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
    end

    res_nxt.credits_left  = item_credit;
    res_nxt.queue_level   = count_nxt;
    res_nxt.timer_running = timer_nxt;

    // the register is written at this same edge, so load the incoming value
    credit_nxt = cfg_load_credit ? cfg_credit_val : item_credit;

    // prefetch the next head; forward a write landing on it this cycle
    qacc.raddr = head_nxt;
    fwd_nxt    = qacc.we && (tail_r == head_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= CREDIT_MAX_RST;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      timer_r  <= 1'b0;
      tick_r   <= '0;
      fwd_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      credit_r <= credit_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      timer_r  <= timer_nxt;
      tick_r   <= tick_nxt;
      fwd_r    <= fwd_nxt;
      strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= qacc.wdata;
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;
  assign strobe = strobe_r;

endmodule

`default_nettype wire

// ===== design/credit_throttle_with_queue.sv =====
// Top level of the credit-based request throttle with its waiting queue.
// The result of a command appears on the out_ ports in the cycle after it is taken.
// Throughput: one command (request or tick) per cycle while rst_n is high; the queue head
//   is prefetched from the registered-read RAM every cycle, so a dequeue never waits on a read.
// Reset: synchronous, rst_n low; credits return to 4, interval to 1200, queue empty,
//   timer stopped. busy is high only while rst_n is low. Results are strobed, not held.
`default_nettype none

module credit_throttle_with_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_opcode,
  input  wire logic [ctq_pkg::TAG_WIDTH-1:0] in_request_tag,
  input  wire logic [1:0]            in_request_method,
  // result channel, one-cycle strobe
  output logic                       out_strobe,
  output logic                       out_issue_valid,
  output logic [ctq_pkg::TAG_WIDTH-1:0] out_issued_tag,
  output logic [1:0]                 out_issued_method,
  output logic                       out_from_queue,
  output logic                       out_dropped,
  output logic [ctq_pkg::CREDIT_W-1:0] out_credits_left,
  output logic [ctq_pkg::CNT_W-1:0]  out_queue_level,
  output logic                       out_timer_running,
  // APB-style register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ctq_pkg::*;

  credit_t     credit_max_r;
  tick_t       tick_interval_r;
  ctq_cfg_t    cfg;
  ctq_reg_t    reg_sel;
  logic        cfg_wr;
  logic        accept;
  ctq_qacc_t   qacc;
  ctq_entry_t  rd_data;
  ctq_result_t result;

  // --- register file -------------------------------------------------
  // Registers sit at 4-byte strides; bit 2 of paddr picks the register.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = ctq_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_max_r    <= CREDIT_MAX_RST;
      tick_interval_r <= TICK_INTERVAL_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_CREDIT_MAX:    credit_max_r    <= pwdata[CREDIT_W-1:0];
        REG_TICK_INTERVAL: tick_interval_r <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CREDIT_MAX:    prdata = {{(32-CREDIT_W){1'b0}}, credit_max_r};
      REG_TICK_INTERVAL: prdata = {{(32-TICK_W){1'b0}}, tick_interval_r};
      default:           prdata = '0;
    endcase
  end

  assign cfg.credit_max    = credit_max_r;
  assign cfg.tick_interval = tick_interval_r;

  // --- command handshake ----------------------------------------------
  // Every command is taken and finished without stalling; only reset holds the channel off.
  assign busy   = !rst_n;
  assign accept = start && !busy;

  // --- waiting queue storage --------------------------------------------
  // Tag and method of each queued request share one RAM word.
  ctq_ram #(
    .WIDTH ($bits(ctq_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (qacc.we),
    .waddr (qacc.waddr),
    .wdata (qacc.wdata),
    .raddr (qacc.raddr),
    .rdata (rd_data)
  );

  // --- credits, refill timer, queue pointers ------------------------------
  // A credit_max write reloads the credit count with the written value;
  // queue and timer are untouched.
  ctq_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .op              (in_opcode),
    .tag             (in_request_tag),
    .method          (in_request_method),
    .cfg             (cfg),
    .cfg_load_credit (cfg_wr && (reg_sel == REG_CREDIT_MAX)),
    .cfg_credit_val  (pwdata[CREDIT_W-1:0]),
    .rd_data         (rd_data),
    .qacc            (qacc),
    .result          (result),
    .strobe          (out_strobe)
  );

  // --- result transaction -------------------------------------------------
  assign out_issue_valid   = result.issue_valid;
  assign out_issued_tag    = result.issued_tag;
  assign out_issued_method = result.issued_method;
  assign out_from_queue    = result.from_queue;
  assign out_dropped       = result.dropped;
  assign out_credits_left  = result.credits_left;
  assign out_queue_level   = result.queue_level;
  assign out_timer_running = result.timer_running;

endmodule

`default_nettype wire

// ===== design/ctq_checker.sv =====
// Port-level checker for the credit throttle, bound to the top level.
`default_nettype none
`include "credit_throttle_with_queue_macros.svh"

module ctq_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  out_strobe,
  input wire logic                  out_issue_valid,
  input wire logic [ctq_pkg::TAG_WIDTH-1:0] out_issued_tag,
  input wire logic [1:0]            out_issued_method,
  input wire logic                  out_from_queue,
  input wire logic                  out_dropped,
  input wire logic [ctq_pkg::CNT_W-1:0] out_queue_level,
  input wire logic                  out_timer_running
);

  `CTQ_ASSERT_NEXT(a_result_follows, start && !busy, out_strobe, "accepted transaction gave no result")

  `CTQ_ASSERT_NEXT(a_no_spurious, !(start && !busy), !out_strobe, "result without a transaction")

  `CTQ_ASSERT_NOW(a_drop_excl, out_strobe && out_dropped, !out_issue_valid && !out_from_queue, "dropped request was issued")

  `CTQ_ASSERT_NOW(a_queue_timer, out_strobe && (out_queue_level != '0), out_timer_running, "requests wait with timer stopped")

  `CTQ_ASSERT_NOW(a_idle_fields, out_strobe && !out_issue_valid, (out_issued_tag == '0) && (out_issued_method == 2'd0) && !out_from_queue, "issue fields set with nothing issued")

endmodule

bind credit_throttle_with_queue ctq_checker u_ctq_checker (.*);

`default_nettype wire

// ===== verif/tb_credit_throttle_with_queue.sv =====
// Self-checking testbench for the credit throttle: command driver, result monitor, predictor.
`default_nettype none

module tb_credit_throttle_with_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import ctq_pkg::*;

  // Run is killed here if the result stream stalls.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Result strobe comes in the cycle after the accepted command; cycles drained at the end.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PHASE_CMDS = 128;

  // One pending command on the input channel.
  typedef struct {
    ctq_op_t    op;
    tag_t       tag;
    logic [1:0] method;
  } cmd_t;

  // Clock, reset and every DUT input start at a known value.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  in_opcode = 1'b0;
  tag_t                  in_request_tag = '0;
  logic [1:0]            in_request_method = '0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;

  logic                  busy;
  logic                  out_strobe;
  logic                  out_issue_valid;
  tag_t                  out_issued_tag;
  logic [1:0]            out_issued_method;
  logic                  out_from_queue;
  logic                  out_dropped;
  credit_t               out_credits_left;
  cnt_t                  out_queue_level;
  logic                  out_timer_running;
  logic [31:0]           prdata;
  logic                  pready;

  credit_throttle_with_queue DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_request_tag    (in_request_tag),
    .in_request_method (in_request_method),
    .out_strobe        (out_strobe),
    .out_issue_valid   (out_issue_valid),
    .out_issued_tag    (out_issued_tag),
    .out_issued_method (out_issued_method),
    .out_from_queue    (out_from_queue),
    .out_dropped       (out_dropped),
    .out_credits_left  (out_credits_left),
    .out_queue_level   (out_queue_level),
    .out_timer_running (out_timer_running),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the throttle state: registers, credits, wait FIFO and refill timer.
  // ---------------------------------------------------------------------------
  ctq_cfg_t   shadow_cfg = '{credit_max: CREDIT_MAX_RST, tick_interval: TICK_INTERVAL_RST};
  credit_t    credits = CREDIT_MAX_RST;
  ctq_entry_t wait_fifo [QUEUE_DEPTH];
  ptr_t       fifo_head = '0;
  ptr_t       fifo_tail = '0;
  cnt_t       fifo_level = '0;
  logic       timer_on = 1'b0;
  tick_t      tick_cnt = '0;

  cmd_t        pending_cmds [$];      // filled by the sequence, drained by the driver
  ctq_result_t expected_results [$];  // one entry per accepted command
  int unsigned mismatches = 0;
  int unsigned accepted = 0;
  int unsigned gap_pct = 16;
  int unsigned cycles = 0;

  // Advance the shadow by one command and return the result the DUT must strobe.
  function automatic ctq_result_t throttle_step(ctq_op_t op, tag_t tag, logic [1:0] method);
    ctq_result_t r;
    logic [TICK_W:0] next_tick;
    r = '0;
    if (op == OP_REQUEST) begin
      if (credits != 0) begin
        // Credit free: issue straight through and spend it.
        credits         = credits - 1'b1;
        r.issue_valid   = 1'b1;
        r.issued_tag    = tag;
        r.issued_method = method;
      end else if (fifo_level < QUEUE_DEPTH) begin
        wait_fifo[fifo_tail].tag    = tag;
        wait_fifo[fifo_tail].method = method;
        fifo_tail  = (fifo_tail == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : fifo_tail + 1'b1;
        fifo_level = fifo_level + 1'b1;
      end else begin
        r.dropped = 1'b1;
      end
      // Any request, dropped or not, kicks a stopped timer from zero.
      if (!timer_on) begin
        timer_on = 1'b1;
        tick_cnt = '0;
      end
    end else if (timer_on) begin
      next_tick = tick_cnt + 1'b1;
      if (next_tick >= shadow_cfg.tick_interval) begin
        tick_cnt = '0;
        if (fifo_level == 0) begin
          // Nothing waiting: refill one credit, stop once full.
          if (credits < shadow_cfg.credit_max) credits = credits + 1'b1;
          if (credits >= shadow_cfg.credit_max) timer_on = 1'b0;
        end else begin
          r.issue_valid   = 1'b1;
          r.from_queue    = 1'b1;
          r.issued_tag    = wait_fifo[fifo_head].tag;
          r.issued_method = wait_fifo[fifo_head].method;
          fifo_head  = (fifo_head == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : fifo_head + 1'b1;
          fifo_level = fifo_level - 1'b1;
        end
      end else begin
        tick_cnt = next_tick[TICK_W-1:0];
      end
    end
    // Ticks while stopped fall through with only the status fields set.
    r.credits_left  = credits;
    r.queue_level   = fifo_level;
    r.timer_running = timer_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents pending commands, predicts each one as it is accepted.
  // Sender gap rate: 16% for the first third, 74% for the second, none after.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_cmds
    cmd_t nxt;
    logic go;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        expected_results.push_back(
          throttle_step(ctq_op_t'(in_opcode), in_request_tag, in_request_method));
        accepted++;
      end
      gap_pct = (accepted < 350) ? 16 : (accepted < 700) ? 74 : 0;
      go = ($urandom_range(0, 99) >= gap_pct);
      if (go && pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        start             <= 1'b1;
        in_opcode         <= nxt.op;
        in_request_tag    <= nxt.tag;
        in_request_method <= nxt.method;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result transaction is matched against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    ctq_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no command outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("issue_valid",   want.issue_valid,   out_issue_valid);
        check_field("issued_tag",    want.issued_tag,    out_issued_tag);
        check_field("issued_method", want.issued_method, out_issued_method);
        check_field("from_queue",    want.from_queue,    out_from_queue);
        check_field("dropped",       want.dropped,       out_dropped);
        check_field("credits_left",  want.credits_left,  out_credits_left);
        check_field("queue_level",   want.queue_level,   out_queue_level);
        check_field("timer_running", want.timer_running, out_timer_running);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers.
  // ---------------------------------------------------------------------------
  task automatic add_cmd(ctq_op_t op, tag_t tag, logic [1:0] method);
    cmd_t c;
    c.op     = op;
    c.tag    = tag;
    c.method = method;
    pending_cmds.push_back(c);
  endtask

  // Random command; requests make up req_pct percent, tags hit both extremes often.
  task automatic add_random_cmd(int unsigned req_pct);
    tag_t tag;
    case ($urandom_range(0, 9))
      0:       tag = '0;
      1:       tag = '1;
      default: tag = tag_t'($urandom);
    endcase
    add_cmd(($urandom_range(0, 99) < req_pct) ? OP_REQUEST : OP_TICK, tag,
            2'($urandom_range(0, 3)));
  endtask

  // Block is idle once nothing is queued, nothing is on the channel and every
  // result has come back. Sampled on the falling edge, clear of the posedge updates.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
  endtask

  // APB write: setup then access, completes on pready. Shadow follows at the same edge.
  task automatic reg_write(ctq_reg_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (idx == REG_CREDIT_MAX) begin
      // Write also reloads the credit count; queue and timer untouched.
      shadow_cfg.credit_max = credit_t'(value);
      credits               = credit_t'(value);
    end else begin
      shadow_cfg.tick_interval = tick_t'(value);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_both(credit_t cmax, tick_t interval);
    if ($urandom_range(0, 1)) begin
      reg_write(REG_CREDIT_MAX, cmax);
      reg_write(REG_TICK_INTERVAL, interval);
    end else begin
      reg_write(REG_TICK_INTERVAL, interval);
      reg_write(REG_CREDIT_MAX, cmax);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    credit_t     phase_cmax [NUM_PHASES];
    tick_t       phase_tint [NUM_PHASES];
    int unsigned req_pct;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: tick on a stopped timer, then spend all four
    // credits with extreme tags and every method, then tick a running timer.
    @(negedge clk);
    add_cmd(OP_TICK,    16'h0000, 2'd0);
    add_cmd(OP_REQUEST, 16'h0000, 2'd0);
    add_cmd(OP_REQUEST, 16'hFFFF, 2'd3);
    add_cmd(OP_REQUEST, 16'h1234, 2'd1);
    add_cmd(OP_REQUEST, 16'hABCD, 2'd2);
    add_cmd(OP_TICK,    16'hFFFF, 2'd3);
    add_cmd(OP_TICK,    16'h5A5A, 2'd1);
    wait_idle();

    // Directed, no credits and zero interval: fill the FIFO, overflow it once
    // (dropped), then every tick is an event and pulls from the head.
    write_both(credit_t'(0), tick_t'(0));
    @(negedge clk);
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      add_cmd(OP_REQUEST, tag_t'(16'hF000 + i * 16'h0111), 2'(i));
    add_cmd(OP_TICK, 16'h0000, 2'd0);
    add_cmd(OP_TICK, 16'h0000, 2'd0);
    wait_idle();

    // Random phases over a spread of settings, extremes included.
    phase_cmax = '{credit_t'(15), credit_t'(1), credit_t'(0), credit_t'(15),
                   credit_t'($urandom_range(1, 15)), credit_t'(2),
                   credit_t'($urandom_range(0, 15)), CREDIT_MAX_RST};
    phase_tint = '{tick_t'(65535), tick_t'(1), tick_t'(2), tick_t'(3),
                   tick_t'($urandom_range(1, 6)), tick_t'(0),
                   tick_t'($urandom_range(1, 24)), TICK_INTERVAL_RST};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_both(phase_cmax[p], phase_tint[p]);
      req_pct = $urandom_range(35, 75);
      @(negedge clk);
      for (int i = 0; i < PHASE_CMDS; i++) add_random_cmd(req_pct);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
